>>> rtl/core/bcst_pkg.sv
// ----------------------------------------------------------------------------
// bcst_pkg
// Shared constants and types for the bitwise context / stride tracker.
// ----------------------------------------------------------------------------
package bcst_pkg;

  // Byte history ring (power of two depth)
  localparam int HIST_DEPTH = 1024;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int FILL_W     = HIST_AW + 1;

  // Byte positions are kept modulo 2^POS_BITS
  localparam int POS_BITS   = 32;

  // Last-position tables, indexed by byte value
  localparam int BYTE_W     = 8;
  localparam int TBL_DEPTH  = 256;
  localparam int TBL_W      = 3 * POS_BITS;

  // Stride and configuration widths
  localparam int STRIDE_W   = 10;
  localparam int CONF_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;

  localparam logic [STRIDE_W-1:0] MAX_STRIDE_RST = STRIDE_W'(1000);
  localparam logic [CONF_W-1:0]   CONFIRM_RST    = CONF_W'(3);
  localparam logic [STRIDE_W-1:0] MIN_STRIDE     = STRIDE_W'(2);
  localparam logic [CONF_W-1:0]   REPS_MAX       = CONF_W'(3);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_STRIDE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM    = 1'b1;

  // Work stage states
  typedef enum logic [1:0] {
    S1_EMPTY,
    S1_DETECT,
    S1_READ,
    S1_DATA
  } s1_state_t;

  // Table lookup request from the bit front end to the stride detector
  typedef struct packed {
    logic              req;
    logic [BYTE_W-1:0] value;
  } lookup_t;

endpackage

>>> rtl/core/bcst_ram.sv
// ----------------------------------------------------------------------------
// bcst_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data that holds while no read is issued.
// ----------------------------------------------------------------------------
module bcst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/bcst_stride_det.sv
// ----------------------------------------------------------------------------
// bcst_stride_det
// Record stride detector: keeps the byte position counter and the three
// last-position tables (one RAM row per byte value), and adopts a stride once
// equal spacing has repeated often enough.
// ----------------------------------------------------------------------------
module bcst_stride_det (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bcst_pkg::lookup_t                 lookup,
  input  logic [bcst_pkg::STRIDE_W-1:0]     max_stride,
  input  logic [bcst_pkg::CONF_W-1:0]       confirm_count,
  output logic [bcst_pkg::STRIDE_W-1:0]     det_stride
);
  import bcst_pkg::*;

  logic [POS_BITS-1:0]  pos_r;
  logic [BYTE_W-1:0]    val_r;
  logic                 upd_r;
  logic                 row_vld_r;
  logic [TBL_DEPTH-1:0] vld_r;
  logic [STRIDE_W-1:0]  cand_r;
  logic [CONF_W-1:0]    reps_r;
  logic [STRIDE_W-1:0]  det_r;

  logic [TBL_W-1:0]     tbl_rdata;
  logic [TBL_W-1:0]     tbl_wdata;
  logic [POS_BITS-1:0]  p1, p2, p3;
  logic [POS_BITS-1:0]  gap, d12, d23;
  logic                 hit;
  logic [STRIDE_W-1:0]  cand_nxt;
  logic [CONF_W-1:0]    reps_nxt;

  // position table: {last_one, last_two, last_three} per byte value
  bcst_ram #(
    .WIDTH (TBL_W),
    .DEPTH (TBL_DEPTH)
  ) u_pos_tbl (
    .clk   (clk),
    .we    (upd_r),
    .waddr (val_r),
    .wdata (tbl_wdata),
    .re    (lookup.req),
    .raddr (lookup.value),
    .rdata (tbl_rdata)
  );

  // rows never written read as zero
  assign p1 = row_vld_r ? tbl_rdata[3*POS_BITS-1:2*POS_BITS] : '0;
  assign p2 = row_vld_r ? tbl_rdata[2*POS_BITS-1:POS_BITS]   : '0;
  assign p3 = row_vld_r ? tbl_rdata[POS_BITS-1:0]            : '0;

  assign tbl_wdata = {pos_r, p1, p2};

  // gap tests, modulo 2^POS_BITS
  assign gap = pos_r - p1;
  assign d12 = p1 - p2;
  assign d23 = p2 - p3;
  assign hit = (gap > POS_BITS'(1))
            && (gap[POS_BITS-1:STRIDE_W] == '0)
            && (gap[STRIDE_W-1:0] <= max_stride)
            && (gap == d12) && (gap == d23);

  // candidate tracking
  always_comb begin
    cand_nxt = cand_r;
    reps_nxt = reps_r;
    if (gap[STRIDE_W-1:0] == cand_r) begin
      if (reps_r < REPS_MAX) begin
        reps_nxt = reps_r + CONF_W'(1);
      end
    end else begin
      cand_nxt = gap[STRIDE_W-1:0];
      reps_nxt = CONF_W'(1);
    end
  end

  // lookup bookkeeping, the cycle before the update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      upd_r <= 1'b0;
    end else begin
      upd_r <= lookup.req;
      if (lookup.req) begin
        pos_r <= pos_r + POS_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (lookup.req) begin
      val_r     <= lookup.value;
      row_vld_r <= vld_r[lookup.value];
    end
  end

  // row valid bits stand in for the all-zero reset of the tables
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (upd_r) begin
      vld_r[val_r] <= 1'b1;
    end
  end

  // stride adoption
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_r <= '0;
      reps_r <= '0;
      det_r  <= '0;
    end else if (upd_r && hit) begin
      cand_r <= cand_nxt;
      reps_r <= reps_nxt;
      if (reps_nxt >= confirm_count) begin
        det_r <= gap[STRIDE_W-1:0];
      end
    end
  end

  assign det_stride = det_r;

  // a new lookup never lands on a pending update
  a_no_lookup_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    upd_r |-> !lookup.req)
    else $error("stride table lookup during update");

  // repeat counter stays at one or more once a candidate exists
  a_reps_after_cand: assert property (@(posedge clk) disable iff (!rst_n)
    (upd_r && hit) |=> (reps_r != '0))
    else $error("candidate adopted with zero repeats");

endmodule

>>> rtl/core/bitwise_context_stride_tracker_unit.sv
// ----------------------------------------------------------------------------
// bitwise_context_stride_tracker_unit
// Bit-serial context builder for a bitwise compressor, with record stride
// detection over a byte history ring.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_new_bit) takes one coded bit per
//   transfer, MSB of each byte first. Every input transfer yields exactly one
//   result transfer on the output channel (out_valid / out_stall / out_*),
//   carrying the contexts for the next bit.
//   Path: a bit that does not end a byte goes through the DATA state of the
//   work stage into the output register; the eighth bit of a byte goes through
//   the DETECT, READ and DATA states, since it needs a position table
//   read-modify-write and then a ring read at the possibly new stride.
//   Throughput: one bit per cycle for seven bits of a byte while the output
//   does not stall; the eighth holds the input in DETECT and READ.
//   The position table RAM and the single ring read per result set this.
//   Reset (rst_n low, synchronous): all history reads as zero through a ring
//   fill count and per-row valid bits, so no clearing pass is run and the
//   block takes bits on the first cycle after reset.
//   Receiver stall: the output register holds; at most one more bit is taken
//   into an empty work stage, after which in_stall rises.
//   Configuration (cfg_we / cfg_index / cfg_data) only while idle.
// ----------------------------------------------------------------------------
module bitwise_context_stride_tracker_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_we,
  input  logic [bcst_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bcst_pkg::CFG_DATA_W-1:0]   cfg_data,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_new_bit,
  // output channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [7:0]                        out_bit_context,
  output logic [7:0]                        out_last_byte,
  output logic [15:0]                       out_last_byte_context,
  output logic [15:0]                       out_second_last_context,
  output logic [15:0]                       out_two_bytes_direct,
  output logic [15:0]                       out_two_bytes_previous,
  output logic [7:0]                        out_stride_byte,
  output logic [7:0]                        out_third_byte,
  output logic [7:0]                        out_fourth_byte,
  output logic [bcst_pkg::STRIDE_W-1:0]     out_active_stride,
  output logic                              out_byte_done
);
  import bcst_pkg::*;

  // configuration registers
  logic [STRIDE_W-1:0] max_stride_r;
  logic [CONF_W-1:0]   confirm_r;

  // bit front end and history state
  logic [BYTE_W-1:0]   pb_r;
  logic [BYTE_W-1:0]   pb_nxt;
  logic [BYTE_W-1:0]   byte_val;
  logic [HIST_AW-1:0]  ptr_r;
  logic [FILL_W-1:0]   fill_r;
  logic [BYTE_W-1:0]   r0_r, r1_r, r2_r, r3_r;

  // work stage
  s1_state_t           st_r, st_nxt;
  logic                s1_done_r;
  logic                s1_ok_r;

  // handshake and control
  logic                out_free;
  logic                s1_move;
  logic                in_ready;
  logic                acc;
  logic                acc_done;
  logic                ring_re;
  lookup_t             lookup;

  // stride and ring read
  logic [STRIDE_W-1:0] det_stride;
  logic [STRIDE_W-1:0] act;
  logic [HIST_AW-1:0]  back;
  logic [HIST_AW-1:0]  ring_raddr;
  logic [BYTE_W-1:0]   ring_rdata;
  logic                back_ok;

  // output register
  logic                out_valid_r;

  // --------------------------------------------------------------------------
  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_stride_r <= MAX_STRIDE_RST;
      confirm_r    <= CONFIRM_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_STRIDE: max_stride_r <= cfg_data[STRIDE_W-1:0];
        CFG_CONFIRM:    confirm_r    <= cfg_data[CONF_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // handshake
  assign out_free = !out_valid_r || !out_stall;
  assign s1_move  = (st_r == S1_DATA) && out_free;
  assign in_ready = (st_r == S1_EMPTY) || s1_move;
  assign in_stall = !in_ready;
  assign acc      = in_valid && in_ready;
  assign acc_done = acc && pb_r[BYTE_W-1];

  // --------------------------------------------------------------------------
  // work stage: next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S1_EMPTY: begin
        if (acc) begin
          st_nxt = pb_r[BYTE_W-1] ? S1_DETECT : S1_DATA;
        end
      end
      S1_DETECT: st_nxt = S1_READ;
      S1_READ:   st_nxt = S1_DATA;
      S1_DATA: begin
        if (s1_move) begin
          if (acc) begin
            st_nxt = pb_r[BYTE_W-1] ? S1_DETECT : S1_DATA;
          end else begin
            st_nxt = S1_EMPTY;
          end
        end
      end
      default: st_nxt = S1_EMPTY;
    endcase
  end

  // work stage: outputs
  always_comb begin
    ring_re      = 1'b0;
    lookup.req   = 1'b0;
    lookup.value = byte_val;
    unique case (st_r)
      S1_EMPTY, S1_DATA: begin
        ring_re    = acc && !pb_r[BYTE_W-1];
        lookup.req = acc_done;
      end
      S1_READ:   ring_re = 1'b1;
      S1_DETECT: ring_re = 1'b0;
      default:   ring_re = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S1_EMPTY;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_done_r <= pb_r[BYTE_W-1];
    end
    if (ring_re) begin
      s1_ok_r <= back_ok;
    end
  end

  // --------------------------------------------------------------------------
  // partial byte with leading one; a full byte leaves it at one
  assign byte_val = {pb_r[BYTE_W-2:0], in_new_bit};
  assign pb_nxt   = pb_r[BYTE_W-1] ? BYTE_W'(1) : byte_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pb_r <= BYTE_W'(1);
    end else if (acc) begin
      pb_r <= pb_nxt;
    end
  end

  // ring pointer, fill count and the four most recent bytes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r  <= '0;
      fill_r <= '0;
      r0_r   <= '0;
      r1_r   <= '0;
      r2_r   <= '0;
      r3_r   <= '0;
    end else if (acc_done) begin
      ptr_r <= ptr_r + HIST_AW'(1);
      if (fill_r < FILL_W'(HIST_DEPTH)) begin
        fill_r <= fill_r + FILL_W'(1);
      end
      r0_r <= byte_val;
      r1_r <= r0_r;
      r2_r <= r1_r;
      r3_r <= r2_r;
    end
  end

  // --------------------------------------------------------------------------
  // stride detector
  bcst_stride_det u_det (
    .clk           (clk),
    .rst_n         (rst_n),
    .lookup        (lookup),
    .max_stride    (max_stride_r),
    .confirm_count (confirm_r),
    .det_stride    (det_stride)
  );

  // stride in use and the ring read one stride back
  assign act        = ((det_stride >= MIN_STRIDE) && (det_stride <= max_stride_r))
                    ? det_stride : MIN_STRIDE;
  assign back       = HIST_AW'(act - STRIDE_W'(1));
  assign ring_raddr = ptr_r - back;
  assign back_ok    = {1'b0, back} < fill_r;

  bcst_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (HIST_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (acc_done),
    .waddr (ptr_r + HIST_AW'(1)),
    .wdata (byte_val),
    .re    (ring_re),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  // --------------------------------------------------------------------------
  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_bit_context         <= pb_r - BYTE_W'(1);
      out_last_byte           <= r0_r;
      out_last_byte_context   <= {r0_r, pb_r - BYTE_W'(1)};
      out_second_last_context <= {r1_r, pb_r - BYTE_W'(1)};
      out_two_bytes_direct    <= {r1_r, r0_r};
      out_two_bytes_previous  <= {r2_r, r1_r};
      out_stride_byte         <= s1_ok_r ? ring_rdata : '0;
      out_third_byte          <= r2_r;
      out_fourth_byte         <= r3_r;
      out_active_stride       <= act;
      out_byte_done           <= s1_done_r;
    end
  end

  assign out_valid = out_valid_r;

  // --------------------------------------------------------------------------
  // assertions
  a_done_goes_detect: assert property (@(posedge clk) disable iff (!rst_n)
    acc_done |=> (st_r == S1_DETECT))
    else $error("byte completion did not enter detect");

  a_no_read_over_held: assert property (@(posedge clk) disable iff (!rst_n)
    ((st_r == S1_DATA) && !s1_move) |-> !ring_re)
    else $error("ring read would overwrite held stride byte");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(HIST_DEPTH))
    else $error("ring fill count beyond depth");

  a_partial_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    pb_r != '0)
    else $error("partial byte lost its leading one");

endmodule
